FILE: src/gfkp_pkg.sv
`timescale 1ns / 1ps
// Package for the GTP-U flow key parser: result type and protocol constants.
// Used by the parser, the output register and the top level; depends on nothing.
package gfkp_pkg;

	localparam logic [15:0] GTPU_PORT_RESET = 16'd2152;
	localparam logic [15:0] ETHERTYPE_IPV4  = 16'h0800;
	localparam logic [15:0] ETHERTYPE_ARP   = 16'h0806;
	localparam logic [7:0]  PROTO_ICMP      = 8'd1;
	localparam logic [7:0]  PROTO_TCP       = 8'd6;
	localparam logic [7:0]  PROTO_UDP       = 8'd17;
	localparam logic [7:0]  ETH_HDR_LEN     = 8'd14;
	localparam logic [31:0] ALL_ONES32      = 32'hFFFF_FFFF;
	localparam logic [15:0] ALL_ONES16      = 16'hFFFF;

	typedef struct packed {
		logic        fwd_gate;
		logic        meta_valid;
		logic [31:0] src_ip;
		logic [31:0] dst_ip;
		logic [15:0] sport;
		logic [15:0] dport;
		logic [31:0] tunnel_id;
		logic [31:0] tunnel_dst_ip;
		logic [7:0]  proto_num;
	} flow_key_t;

endpackage

FILE: src/gtpu_flow_key_parser_core.sv
`timescale 1ns / 1ps
// Top level of the GTP-U flow key parser: input register, config register, stream ports.
// Depends on gfkp_pkg, gfkp_parser and gfkp_out_reg.
// Throughput is one frame byte per cycle, except while a last byte waits for the result register to be free;
// the parser state advances once per byte. A frame's result reaches the master side through the input
// register and then the result register.
// Reset clears the parse state and both registers' valid flags and sets gtpu_udp_port to 2152.
module gtpu_flow_key_parser_core (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,  // [7:0] data_byte
	input  logic         s_tlast,  // last_byte
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [167:0] m_tdata,  // src_ip, dst_ip, sport, dport, tunnel_id,
	                               // tunnel_dst_ip, proto_num
	output logic [1:0]   m_tuser,  // [0] fwd_gate, [1] meta_valid
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [15:0]  cfg_data  // gtpu_udp_port
);

	logic                s1_valid;
	logic [7:0]          data_s1;
	logic                last_s1;
	logic [15:0]         gtpu_port_q;
	logic                out_ready;
	logic                advance;
	gfkp_pkg::flow_key_t key;
	gfkp_pkg::flow_key_t key_out;

	assign advance   = s1_valid && (!last_s1 || out_ready);
	assign s_tready  = !s1_valid || advance;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid    <= 1'b0;
			gtpu_port_q <= gfkp_pkg::GTPU_PORT_RESET;
		end else begin
			if (s_tready) begin
				s1_valid <= s_tvalid;
			end
			if (cfg_valid) begin
				gtpu_port_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			data_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	gfkp_parser u_parser (
		.clk           (clk),
		.arst_n        (arst_n),
		.advance       (advance),
		.data_byte     (data_s1),
		.last_byte     (last_s1),
		.gtpu_udp_port (gtpu_port_q),
		.result        (key)
	);

	gfkp_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (advance && last_s1),
		.in_ready  (out_ready),
		.in_key    (key),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_key   (key_out)
	);

	assign m_tdata = {key_out.proto_num, key_out.tunnel_dst_ip, key_out.tunnel_id,
	                  key_out.dport, key_out.sport, key_out.dst_ip, key_out.src_ip};
	assign m_tuser = {key_out.meta_valid, key_out.fwd_gate};

endmodule

FILE: src/gfkp_parser.sv
`timescale 1ns / 1ps
// Byte-wide header walker: per-frame parse state and the flow key it produces.
// Uses gfkp_pkg for constants and the flow_key_t result type.
module gfkp_parser (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   advance,
	input  logic [7:0]             data_byte,
	input  logic                   last_byte,
	input  logic [15:0]            gtpu_udp_port,
	output gfkp_pkg::flow_key_t    result
);

	localparam logic [2:0] PH_ETH    = 3'd0;
	localparam logic [2:0] PH_IP_OUT = 3'd1;
	localparam logic [2:0] PH_L4_OUT = 3'd2;
	localparam logic [2:0] PH_GTP    = 3'd3;
	localparam logic [2:0] PH_IP_IN  = 3'd4;
	localparam logic [2:0] PH_L4_IN  = 3'd5;
	localparam logic [2:0] PH_DONE   = 3'd6;
	localparam logic [2:0] PH_SKIP   = 3'd7;

	logic [7:0]  offset_q, offset_n;
	logic [2:0]  phase_q, phase_n;
	logic [15:0] kind_q, kind_n;
	logic [7:0]  ip_start_q, ip_start_n;
	logic [7:0]  l4_start_q, l4_start_n;
	logic [7:0]  proto_q, proto_n;
	logic [31:0] src_addr_q, src_addr_n;
	logic [31:0] dst_addr_q, dst_addr_n;
	logic [15:0] sport_q, sport_n;
	logic [15:0] dport_q, dport_n;

	logic        inner;
	logic [7:0]  rel_ip;
	logic [7:0]  rel_l4;
	logic [3:0]  ihl;
	logic        fwd;
	logic        valid;

	assign inner  = (phase_q == PH_IP_IN) || (phase_q == PH_L4_IN);
	assign rel_ip = offset_q - ip_start_q;
	assign rel_l4 = offset_q - l4_start_q;
	assign ihl    = (data_byte[3:0] < 4'd5) ? 4'd5 : data_byte[3:0];

	always_comb begin
		offset_n   = (offset_q != 8'hFF) ? offset_q + 8'd1 : offset_q;
		phase_n    = phase_q;
		kind_n     = kind_q;
		ip_start_n = ip_start_q;
		l4_start_n = l4_start_q;
		proto_n    = proto_q;
		src_addr_n = src_addr_q;
		dst_addr_n = dst_addr_q;
		sport_n    = sport_q;
		dport_n    = dport_q;
		case (phase_q)
			PH_ETH: begin
				if (offset_q == 8'd12 || offset_q == 8'd13) begin
					kind_n = {kind_q[7:0], data_byte};
				end
				if (offset_q == 8'd13) begin
					if ({kind_q[7:0], data_byte} == gfkp_pkg::ETHERTYPE_IPV4 ||
					    {kind_q[7:0], data_byte} == gfkp_pkg::ETHERTYPE_ARP) begin
						ip_start_n = gfkp_pkg::ETH_HDR_LEN;
						phase_n    = PH_IP_OUT;
					end else begin
						phase_n = PH_SKIP;
					end
				end
			end
			PH_IP_OUT, PH_IP_IN: begin
				if (offset_q >= ip_start_q) begin
					if (rel_ip == 8'd0) begin
						l4_start_n = ip_start_q + {2'b00, ihl, 2'b00};
					end else if (rel_ip == 8'd9) begin
						proto_n = data_byte;
						if (inner) begin
							if (data_byte != gfkp_pkg::PROTO_TCP &&
							    data_byte != gfkp_pkg::PROTO_UDP) begin
								phase_n = PH_SKIP;
							end
						end else if (data_byte != gfkp_pkg::PROTO_ICMP &&
						             data_byte != gfkp_pkg::PROTO_TCP &&
						             data_byte != gfkp_pkg::PROTO_UDP) begin
							phase_n = PH_SKIP;
						end
					end else if (rel_ip inside {[8'd12:8'd15]}) begin
						src_addr_n = {src_addr_q[23:0], data_byte};
					end else if (rel_ip inside {[8'd16:8'd19]}) begin
						dst_addr_n = {dst_addr_q[23:0], data_byte};
						if (rel_ip == 8'd19) begin
							if (!inner && proto_q == gfkp_pkg::PROTO_ICMP) begin
								sport_n = gfkp_pkg::ALL_ONES16;
								dport_n = gfkp_pkg::ALL_ONES16;
								phase_n = PH_DONE;
							end else begin
								phase_n = inner ? PH_L4_IN : PH_L4_OUT;
							end
						end
					end
				end
			end
			PH_L4_OUT, PH_L4_IN: begin
				if (offset_q >= l4_start_q) begin
					if (rel_l4 <= 8'd1) begin
						sport_n = {sport_q[7:0], data_byte};
					end else if (rel_l4 <= 8'd3) begin
						dport_n = {dport_q[7:0], data_byte};
						if (rel_l4 == 8'd3) begin
							if (!inner && proto_q == gfkp_pkg::PROTO_UDP &&
							    {dport_q[7:0], data_byte} == gtpu_udp_port) begin
								phase_n = PH_GTP;
							end else begin
								phase_n = PH_DONE;
							end
						end
					end
				end
			end
			PH_GTP: begin
				if (offset_q >= l4_start_q && rel_l4 == 8'd8) begin
					ip_start_n = l4_start_q + 8'd8 +
					             ((data_byte[2:0] != 3'd0) ? 8'd12 : 8'd8);
					phase_n    = PH_IP_IN;
				end
			end
			default: begin
			end
		endcase
	end

	assign fwd   = (phase_n != PH_ETH) &&
	               (kind_n == gfkp_pkg::ETHERTYPE_IPV4 || kind_n == gfkp_pkg::ETHERTYPE_ARP);
	assign valid = (phase_n == PH_DONE);

	always_comb begin
		result.fwd_gate      = fwd;
		result.meta_valid    = valid;
		result.src_ip        = valid ? src_addr_n : 32'd0;
		result.dst_ip        = valid ? dst_addr_n : 32'd0;
		result.sport         = valid ? sport_n : 16'd0;
		result.dport         = valid ? dport_n : 16'd0;
		result.tunnel_id     = valid ? gfkp_pkg::ALL_ONES32 : 32'd0;
		result.tunnel_dst_ip = valid ? gfkp_pkg::ALL_ONES32 : 32'd0;
		result.proto_num     = valid ? proto_n : 8'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q   <= '0;
			phase_q    <= PH_ETH;
			kind_q     <= '0;
			ip_start_q <= '0;
			l4_start_q <= '0;
			proto_q    <= '0;
			src_addr_q <= '0;
			dst_addr_q <= '0;
			sport_q    <= '0;
			dport_q    <= '0;
		end else if (advance) begin
			if (last_byte) begin
				offset_q   <= '0;
				phase_q    <= PH_ETH;
				kind_q     <= '0;
				ip_start_q <= '0;
				l4_start_q <= '0;
				proto_q    <= '0;
				src_addr_q <= '0;
				dst_addr_q <= '0;
				sport_q    <= '0;
				dport_q    <= '0;
			end else begin
				offset_q   <= offset_n;
				phase_q    <= phase_n;
				kind_q     <= kind_n;
				ip_start_q <= ip_start_n;
				l4_start_q <= l4_start_n;
				proto_q    <= proto_n;
				src_addr_q <= src_addr_n;
				dst_addr_q <= dst_addr_n;
				sport_q    <= sport_n;
				dport_q    <= dport_n;
			end
		end
	end

endmodule

FILE: src/gfkp_out_reg.sv
`timescale 1ns / 1ps
// Result register: holds one flow key until the downstream side takes it.
// Uses gfkp_pkg for the flow_key_t result type.
module gfkp_out_reg (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  gfkp_pkg::flow_key_t    in_key,
	output logic                   out_valid,
	input  logic                   out_ready,
	output gfkp_pkg::flow_key_t    out_key
);

	logic                valid_q;
	gfkp_pkg::flow_key_t key_q;

	assign in_ready  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_key   = key_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			key_q <= in_key;
		end
	end

endmodule

FILE: src/gfkp_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the GTP-U flow key parser, bound to the top level.
// Depends on gfkp_pkg for protocol codes and on the ports of gtpu_flow_key_parser_core.
module gfkp_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [167:0] m_tdata,
	input logic [1:0]   m_tuser
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("Result changed while stalled.");

	a_valid_fwd: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> m_tuser[0])
		else $error("Flow key written on a default-gate frame.");

	a_empty_key: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[1] |-> m_tdata == 168'd0)
		else $error("Flow fields not cleared when no key was written.");

	a_key_form: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> m_tdata[159:96] == {64{1'b1}} &&
		(m_tdata[167:160] == gfkp_pkg::PROTO_ICMP ||
		 m_tdata[167:160] == gfkp_pkg::PROTO_TCP ||
		 m_tdata[167:160] == gfkp_pkg::PROTO_UDP))
		else $error("Malformed flow key.");

endmodule

bind gtpu_flow_key_parser_core gfkp_checker u_gfkp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
